@@ rtl/ubd_pkg.sv @@
// Shared constants, types and helper functions for the baud divisor calculator.
package ubd_pkg;

    // Field and datapath widths
    localparam int BAUD_W          = 24;
    localparam int CLK_W           = 24;
    localparam int WORD_W          = 26;
    localparam int ERR_W           = 2;
    localparam int NUM_W           = 30;
    localparam int DEN_W           = 26;
    localparam int QUO_W           = 28;
    localparam int MANT_W          = 22;
    localparam int FRAC_W          = 4;
    localparam int REM_W           = 7;
    localparam int FNUM_W          = 11;
    localparam int SHIFT_W         = 4;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = NUM_W / STEPS_PER_STAGE;

    // Register port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register indexes
    localparam logic [1:0] REG_CLOCK_SOURCE = 2'd0;
    localparam logic [1:0] REG_AHB_PRESCALE = 2'd1;
    localparam logic [1:0] REG_APB_LOW      = 2'd2;
    localparam logic [1:0] REG_APB_HIGH     = 2'd3;

    // Clock source codes
    localparam logic [1:0] SRC_INTERNAL = 2'd0;
    localparam logic [1:0] SRC_EXTERNAL = 2'd1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BAUD_ZERO  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_BAD_SOURCE = 2'd2;

    // System clock frequencies
    localparam logic [CLK_W-1:0] SYS_CLK_INTERNAL = 24'd16000000;
    localparam logic [CLK_W-1:0] SYS_CLK_EXTERNAL = 24'd8000000;

    // Reciprocal of 25 for a 26-bit dividend, and of 100 for an 11-bit one
    localparam int               RECIP_25_W     = 27;
    localparam logic [26:0]      RECIP_25       = 27'd85899346;
    localparam int               RECIP_25_SHIFT = 31;
    localparam int               RECIP_25_PW    = DEN_W + RECIP_25_W;
    localparam logic [10:0]      RECIP_100       = 11'd1311;
    localparam int               RECIP_100_SHIFT = 17;
    localparam int               RECIP_100_PW    = 2 * FNUM_W;
    localparam logic [FNUM_W-1:0] ROUND_HALF     = 11'd50;

    typedef struct packed {
        logic [1:0] clock_source;
        logic [3:0] ahb_prescale_code;
        logic [2:0] apb_low_prescale_code;
        logic [2:0] apb_high_prescale_code;
    } ubd_cfg_t;

    typedef struct packed {
        logic [ERR_W-1:0] error_code;
        logic [CLK_W-1:0] bus_clock_hz;
        logic             oversample_by_eight;
    } ubd_side_t;

    // Numerator shifts out on the left while quotient bits shift in on the right
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } ubd_div_t;

    typedef struct packed {
        ubd_side_t side;
        ubd_div_t  div;
    } ubd_item_t;

    // AHB prescaler code to shift amount
    function automatic logic [SHIFT_W-1:0] ahb_shift(input logic [3:0] code);
        logic [SHIFT_W-1:0] s;
        case (code)
            4'd8:    s = 4'd1;
            4'd9:    s = 4'd2;
            4'd10:   s = 4'd3;
            4'd11:   s = 4'd4;
            4'd12:   s = 4'd6;
            4'd13:   s = 4'd7;
            4'd14:   s = 4'd8;
            4'd15:   s = 4'd9;
            default: s = 4'd0;
        endcase
        return s;
    endfunction

    // APB prescaler code to shift amount
    function automatic logic [2:0] apb_shift(input logic [2:0] code);
        logic [2:0] s;
        case (code)
            3'd4:    s = 3'd1;
            3'd5:    s = 3'd2;
            3'd6:    s = 3'd3;
            3'd7:    s = 3'd4;
            default: s = 3'd0;
        endcase
        return s;
    endfunction

    // One restoring division step
    function automatic ubd_div_t div_step(input ubd_div_t d);
        ubd_div_t         r;
        logic [DEN_W:0]   part;
        logic [DEN_W+1:0] diff;
        r     = d;
        part  = {d.rem, d.num[NUM_W-1]};
        diff  = {1'b0, part} - {2'b00, d.den};
        r.num = {d.num[NUM_W-2:0], ~diff[DEN_W+1]};
        r.rem = diff[DEN_W+1] ? part[DEN_W-1:0] : diff[DEN_W-1:0];
        return r;
    endfunction

endpackage

@@ rtl/uart_baud_divisor_calc.sv @@
// Top level of the pipelined fractional baud rate divisor calculator.
//
//   Channel   Handshake                  Payload
//   --------  -------------------------  ----------------------------------------------
//   request   in_valid / in_ready        baud_rate, oversample_by_eight, on_second_bus
//   result    out_valid / out_ready      divisor_word, bus_clock_hz, error_code
//   config    psel, penable, pwrite      paddr, pwdata -> prdata, pready (always high)
//
// A request can enter every cycle unless a stalled result has backed up the pipeline.
// It passes 19 register stages: one front stage, 15 divider stages of two restoring steps
// each, and three stages for mantissa, fraction and the output register, the last of which
// holds the result. Most of the pipeline depth lies in the divider stages.
// rst_n clears the valid bits and the configuration registers; payload registers are not reset.
// Each stage advances when it is empty or its successor advances, so a stalled result
// holds in place while bubbles further up still fill with new requests.
module uart_baud_divisor_calc (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ubd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ubd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ubd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [ubd_pkg::BAUD_W-1:0]       baud_rate,
    input  logic                             oversample_by_eight,
    input  logic                             on_second_bus,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [ubd_pkg::WORD_W-1:0]       divisor_word,
    output logic [ubd_pkg::CLK_W-1:0]        bus_clock_hz,
    output logic [ubd_pkg::ERR_W-1:0]        error_code
);

    ubd_pkg::ubd_cfg_t  cfg;
    logic               stg_valid [0:ubd_pkg::DIV_STAGES];
    logic               stg_ready [0:ubd_pkg::DIV_STAGES];
    ubd_pkg::ubd_item_t stg_item  [0:ubd_pkg::DIV_STAGES];

    // Configuration registers
    ubd_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Bus clock and division operands
    ubd_prep u_prep (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cfg                 (cfg),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .baud_rate           (baud_rate),
        .oversample_by_eight (oversample_by_eight),
        .on_second_bus       (on_second_bus),
        .out_valid           (stg_valid[0]),
        .out_ready           (stg_ready[0]),
        .out_item            (stg_item[0])
    );

    // Divider pipeline
    for (genvar g = 0; g < ubd_pkg::DIV_STAGES; g++)
    begin : g_div
        ubd_div_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[g]),
            .in_ready  (stg_ready[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_ready (stg_ready[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    // Mantissa, fraction and output register
    ubd_post u_post (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (stg_valid[ubd_pkg::DIV_STAGES]),
        .in_ready     (stg_ready[ubd_pkg::DIV_STAGES]),
        .in_item      (stg_item[ubd_pkg::DIV_STAGES]),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .divisor_word (divisor_word),
        .bus_clock_hz (bus_clock_hz),
        .error_code   (error_code)
    );

endmodule

@@ rtl/ubd_regs.sv @@
// APB register file holding the clock source and prescaler codes.
module ubd_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [ubd_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [ubd_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [ubd_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output ubd_pkg::ubd_cfg_t                cfg
);

    ubd_pkg::ubd_cfg_t cfg_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                ubd_pkg::REG_CLOCK_SOURCE: cfg_reg.clock_source <= pwdata[1:0];
                ubd_pkg::REG_AHB_PRESCALE: cfg_reg.ahb_prescale_code <= pwdata[3:0];
                ubd_pkg::REG_APB_LOW:      cfg_reg.apb_low_prescale_code <= pwdata[2:0];
                ubd_pkg::REG_APB_HIGH:     cfg_reg.apb_high_prescale_code <= pwdata[2:0];
                default:                   cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Read back the addressed register
    always_comb
    begin
        case (reg_idx)
            ubd_pkg::REG_CLOCK_SOURCE: prdata = {30'd0, cfg_reg.clock_source};
            ubd_pkg::REG_AHB_PRESCALE: prdata = {28'd0, cfg_reg.ahb_prescale_code};
            ubd_pkg::REG_APB_LOW:      prdata = {29'd0, cfg_reg.apb_low_prescale_code};
            ubd_pkg::REG_APB_HIGH:     prdata = {29'd0, cfg_reg.apb_high_prescale_code};
            default:                   prdata = '0;
        endcase
    end

endmodule

@@ rtl/ubd_prep.sv @@
// Front stage: derive the bus clock, form the scaled numerator and the denominator.
module ubd_prep (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ubd_pkg::ubd_cfg_t              cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ubd_pkg::BAUD_W-1:0]     baud_rate,
    input  logic                           oversample_by_eight,
    input  logic                           on_second_bus,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ubd_pkg::ubd_item_t             out_item
);

    logic                              valid_reg;
    ubd_pkg::ubd_item_t                item_reg;
    ubd_pkg::ubd_item_t                item_next;
    logic                              src_ok;
    logic [ubd_pkg::CLK_W-1:0]         sys_clk;
    logic [ubd_pkg::SHIFT_W-1:0]       shift_amt;
    logic [2:0]                        apb_code;
    logic [ubd_pkg::CLK_W-1:0]         bus_clk;
    logic [ubd_pkg::NUM_W-1:0]         bus_wide;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Pick the bus clock and build the division operands
    always_comb
    begin
        src_ok    = (cfg.clock_source == ubd_pkg::SRC_INTERNAL) ||
                    (cfg.clock_source == ubd_pkg::SRC_EXTERNAL);
        sys_clk   = (cfg.clock_source == ubd_pkg::SRC_INTERNAL) ?
                    ubd_pkg::SYS_CLK_INTERNAL : ubd_pkg::SYS_CLK_EXTERNAL;
        apb_code  = on_second_bus ? cfg.apb_high_prescale_code : cfg.apb_low_prescale_code;
        shift_amt = ubd_pkg::ahb_shift(cfg.ahb_prescale_code) +
                    {1'b0, ubd_pkg::apb_shift(apb_code)};
        bus_clk   = sys_clk >> shift_amt;
        bus_wide  = ubd_pkg::NUM_W'(bus_clk);

        item_next.div.num = (bus_wide << 4) + (bus_wide << 3) + bus_wide;
        item_next.div.rem = '0;
        item_next.div.den = oversample_by_eight ? {1'b0, baud_rate, 1'b0} : {baud_rate, 2'b00};

        item_next.side.oversample_by_eight = oversample_by_eight;
        item_next.side.bus_clock_hz        = src_ok ? bus_clk : '0;
        if (!src_ok)
        begin
            item_next.side.error_code = ubd_pkg::ERR_BAD_SOURCE;
        end
        else if (baud_rate == '0)
        begin
            item_next.side.error_code = ubd_pkg::ERR_BAUD_ZERO;
        end
        else
        begin
            item_next.side.error_code = ubd_pkg::ERR_NONE;
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Load the request
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/ubd_div_stage.sv @@
// One divider pipeline stage: a fixed number of restoring steps, then a register.
module ubd_div_stage (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ubd_pkg::ubd_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output ubd_pkg::ubd_item_t  out_item
);

    logic               valid_reg;
    ubd_pkg::ubd_item_t item_reg;
    ubd_pkg::ubd_item_t item_next;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    // Run the division steps of this stage
    always_comb
    begin
        item_next = in_item;
        for (int i = 0; i < ubd_pkg::STEPS_PER_STAGE; i++)
        begin
            item_next.div = ubd_pkg::div_step(item_next.div);
        end
    end

    // Advance the valid bit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // Hold the partial quotient and remainder
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_next;
        end
    end

endmodule

@@ rtl/ubd_post.sv @@
// Back stages: split the scaled divider into mantissa and rounded fraction, pack the word.
module ubd_post (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  ubd_pkg::ubd_item_t           in_item,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [ubd_pkg::WORD_W-1:0]   divisor_word,
    output logic [ubd_pkg::CLK_W-1:0]    bus_clock_hz,
    output logic [ubd_pkg::ERR_W-1:0]    error_code
);

    // Stage 1: mantissa by reciprocal multiply
    logic                                v1_reg;
    logic                                r1;
    ubd_pkg::ubd_side_t                  side1_reg;
    logic [ubd_pkg::MANT_W-1:0]          mant1_reg;
    logic [ubd_pkg::REM_W-1:0]           low1_reg;
    logic [ubd_pkg::DEN_W-1:0]           quo_div4;
    logic [ubd_pkg::RECIP_25_PW-1:0]     mant_prod;

    // Stage 2: remainder and rounding numerator
    logic                                v2_reg;
    logic                                r2;
    ubd_pkg::ubd_side_t                  side2_reg;
    logic [ubd_pkg::MANT_W-1:0]          mant2_reg;
    logic [ubd_pkg::FNUM_W-1:0]          fnum2_reg;
    logic [ubd_pkg::REM_W-1:0]           m7;
    logic [ubd_pkg::REM_W-1:0]           rem7;
    logic [ubd_pkg::FNUM_W-1:0]          fnum_next;

    // Stage 3: rounded fraction and output register
    logic                                v3_reg;
    logic                                r3;
    logic [ubd_pkg::RECIP_100_PW-1:0]    frac_prod;
    logic [ubd_pkg::FRAC_W-1:0]          frac;
    logic [ubd_pkg::WORD_W-1:0]          word_next;
    logic [ubd_pkg::WORD_W-1:0]          word_reg;
    logic [ubd_pkg::CLK_W-1:0]           clk3_reg;
    logic [ubd_pkg::ERR_W-1:0]           err3_reg;

    assign r3       = !v3_reg || out_ready;
    assign r2       = !v2_reg || r3;
    assign r1       = !v1_reg || r2;
    assign in_ready = r1;

    assign out_valid    = v3_reg;
    assign divisor_word = word_reg;
    assign bus_clock_hz = clk3_reg;
    assign error_code   = err3_reg;

    // Divide the quotient by 100 as a divide by 4 then a multiply by 1/25
    always_comb
    begin
        quo_div4  = in_item.div.num[ubd_pkg::QUO_W-1:2];
        mant_prod = ubd_pkg::RECIP_25_PW'(quo_div4) * ubd_pkg::RECIP_25_PW'(ubd_pkg::RECIP_25);
    end

    // Remainder needs only the low bits since it stays below 100
    always_comb
    begin
        m7   = mant1_reg[ubd_pkg::REM_W-1:0];
        rem7 = low1_reg - ((m7 << 6) + (m7 << 5) + (m7 << 2));
        if (side1_reg.oversample_by_eight)
        begin
            fnum_next = {1'b0, rem7, 3'b000} + ubd_pkg::ROUND_HALF;
        end
        else
        begin
            fnum_next = {rem7, 4'b0000} + ubd_pkg::ROUND_HALF;
        end
    end

    // Round the fraction, drop any carry, and pack the word
    always_comb
    begin
        frac_prod = ubd_pkg::RECIP_100_PW'(fnum2_reg) *
                    ubd_pkg::RECIP_100_PW'(ubd_pkg::RECIP_100);
        if (side2_reg.oversample_by_eight)
        begin
            frac = {1'b0, frac_prod[ubd_pkg::RECIP_100_SHIFT +: 3]};
        end
        else
        begin
            frac = frac_prod[ubd_pkg::RECIP_100_SHIFT +: ubd_pkg::FRAC_W];
        end
        word_next = (side2_reg.error_code == ubd_pkg::ERR_NONE) ? {mant2_reg, frac} : '0;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    // Load the payload of each stage
    always_ff @(posedge clk)
    begin
        if (in_valid && r1)
        begin
            side1_reg <= in_item.side;
            mant1_reg <= mant_prod[ubd_pkg::RECIP_25_SHIFT +: ubd_pkg::MANT_W];
            low1_reg  <= in_item.div.num[ubd_pkg::REM_W-1:0];
        end
        if (v1_reg && r2)
        begin
            side2_reg <= side1_reg;
            mant2_reg <= mant1_reg;
            fnum2_reg <= fnum_next;
        end
        if (v2_reg && r3)
        begin
            word_reg <= word_next;
            clk3_reg <= side2_reg.bus_clock_hz;
            err3_reg <= side2_reg.error_code;
        end
    end

endmodule

@@ dv/uart_baud_divisor_calc_tb.sv @@
// Testbench for the fractional baud divisor calculator: directed and random requests.
`timescale 1ns / 1ps

module uart_baud_divisor_calc_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 9;
    localparam int IDLE_PCT     = 31;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 200000;

    typedef struct {
        logic [ubd_pkg::WORD_W-1:0] word;
        logic [ubd_pkg::CLK_W-1:0]  hz;
        logic [ubd_pkg::ERR_W-1:0]  err;
    } baud_result_t;

    logic                           clk;
    logic                           rst_n;
    logic                           psel;
    logic                           penable;
    logic                           pwrite;
    logic [ubd_pkg::APB_ADDR_W-1:0] paddr;
    logic [ubd_pkg::APB_DATA_W-1:0] pwdata;
    logic [ubd_pkg::APB_DATA_W-1:0] prdata;
    logic                           pready;
    logic                           in_valid;
    logic                           in_ready;
    logic [ubd_pkg::BAUD_W-1:0]     baud_rate;
    logic                           oversample_by_eight;
    logic                           on_second_bus;
    logic                           out_valid;
    logic                           out_ready;
    logic [ubd_pkg::WORD_W-1:0]     divisor_word;
    logic [ubd_pkg::CLK_W-1:0]      bus_clock_hz;
    logic [ubd_pkg::ERR_W-1:0]      error_code;

    // Register mirror
    logic [1:0] cfg_src;
    logic [3:0] cfg_ahb;
    logic [2:0] cfg_apb_lo;
    logic [2:0] cfg_apb_hi;

    baud_result_t pending_results[$];
    int           err_count;
    int           cycle_count;
    int           requests_sent;
    int           results_seen;
    int           error_results;
    int           settings_applied;
    bit           steady_flow;
    int           hold_len;

    uart_baud_divisor_calc u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .baud_rate           (baud_rate),
        .oversample_by_eight (oversample_by_eight),
        .on_second_bus       (on_second_bus),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .divisor_word        (divisor_word),
        .bus_clock_hz        (bus_clock_hz),
        .error_code          (error_code)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #(CLK_PERIOD / 2) clk = ~clk;
        end
    end

    // Count cycles for the run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    // Peripheral bus clock from the mirrored prescaler codes
    function automatic logic [ubd_pkg::CLK_W-1:0] bus_clock_for(input bit second);
        longint unsigned sys_hz;
        longint unsigned ahb_div;
        longint unsigned apb_div;
        logic [2:0]      apb_code;
        sys_hz   = (cfg_src == ubd_pkg::SRC_EXTERNAL) ? ubd_pkg::SYS_CLK_EXTERNAL :
                                                        ubd_pkg::SYS_CLK_INTERNAL;
        apb_code = second ? cfg_apb_hi : cfg_apb_lo;
        case (cfg_ahb)
            4'd8:    ahb_div = 2;
            4'd9:    ahb_div = 4;
            4'd10:   ahb_div = 8;
            4'd11:   ahb_div = 16;
            4'd12:   ahb_div = 64;
            4'd13:   ahb_div = 128;
            4'd14:   ahb_div = 256;
            4'd15:   ahb_div = 512;
            default: ahb_div = 1;
        endcase
        case (apb_code)
            3'd4:    apb_div = 2;
            3'd5:    apb_div = 4;
            3'd6:    apb_div = 8;
            3'd7:    apb_div = 16;
            default: apb_div = 1;
        endcase
        return ubd_pkg::CLK_W'((sys_hz / ahb_div) / apb_div);
    endfunction

    // Expected divisor word, bus clock and status for one request
    function automatic baud_result_t predict_divisor(input logic [ubd_pkg::BAUD_W-1:0] baud,
                                                     input bit by8, input bit second);
        baud_result_t    r;
        longint unsigned scaled;
        longint unsigned mant;
        longint unsigned rem;
        longint unsigned frac;
        r.word = '0;
        r.hz   = '0;
        r.err  = ubd_pkg::ERR_NONE;
        if (cfg_src != ubd_pkg::SRC_INTERNAL && cfg_src != ubd_pkg::SRC_EXTERNAL)
        begin
            r.err = ubd_pkg::ERR_BAD_SOURCE;
            return r;
        end
        r.hz = bus_clock_for(second);
        if (baud == 0)
        begin
            r.err = ubd_pkg::ERR_BAUD_ZERO;
            return r;
        end
        scaled = (64'd25 * r.hz) / ((by8 ? 64'd2 : 64'd4) * baud);
        mant   = scaled / 100;
        rem    = scaled - mant * 100;
        // Carry out of the fraction is dropped
        if (by8)
            frac = ((rem * 8 + 50) / 100) & 64'h7;
        else
            frac = ((rem * 16 + 50) / 100) & 64'hF;
        r.word = ubd_pkg::WORD_W'((mant << 4) | frac);
        return r;
    endfunction

    // Baud rates spread over all magnitudes, with zero now and then
    function automatic logic [ubd_pkg::BAUD_W-1:0] random_baud();
        int unsigned nbits;
        if ($urandom_range(0, 99) < 4)
            return '0;
        nbits = $urandom_range(1, ubd_pkg::BAUD_W);
        return ubd_pkg::BAUD_W'($urandom & ((32'd1 << nbits) - 1));
    endfunction

    // Register write: setup then access cycle
    task automatic apb_write(input logic [1:0] idx,
                             input logic [ubd_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            ubd_pkg::REG_CLOCK_SOURCE: cfg_src    = data[1:0];
            ubd_pkg::REG_AHB_PRESCALE: cfg_ahb    = data[3:0];
            ubd_pkg::REG_APB_LOW:      cfg_apb_lo = data[2:0];
            default:                   cfg_apb_hi = data[2:0];
        endcase
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx,
                            output logic [ubd_pkg::APB_DATA_W-1:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apply_settings(input logic [1:0] src, input logic [3:0] ahb,
                                  input logic [2:0] lo, input logic [2:0] hi);
        apb_write(ubd_pkg::REG_CLOCK_SOURCE, {30'd0, src});
        apb_write(ubd_pkg::REG_AHB_PRESCALE, {28'd0, ahb});
        apb_write(ubd_pkg::REG_APB_LOW, {29'd0, lo});
        apb_write(ubd_pkg::REG_APB_HIGH, {29'd0, hi});
        settings_applied++;
    endtask

    // Offer one request and hold it until accepted
    task automatic send_request(input logic [ubd_pkg::BAUD_W-1:0] baud, input bit by8,
                                input bit second);
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid            <= 1'b1;
        baud_rate           <= baud;
        oversample_by_eight <= by8;
        on_second_bus       <= second;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(predict_divisor(baud, by8, second));
        requests_sent++;
    endtask

    task automatic send_random_request();
        send_request(random_baud(), 1'($urandom), 1'($urandom));
    endtask

    // Drop valid and wait for every outstanding result
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: random stalls, plus long hold-offs on request
    initial
    begin
        int hold_left;
        hold_left = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len != 0)
            begin
                hold_left = hold_len;
                hold_len  = 0;
            end
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
                out_ready <= 1'b0;
            else
                out_ready <= 1'b1;
        end
    end

    // Compare each result with the oldest prediction
    always @(posedge clk)
    begin
        baud_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (error_code != ubd_pkg::ERR_NONE)
                error_results++;
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: divisor_word=%0h bus_clock_hz=%0d error_code=%0d",
                       divisor_word, bus_clock_hz, error_code);
                err_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (divisor_word !== want.word)
                begin
                    $error("divisor_word: expected %0h, got %0h", want.word, divisor_word);
                    err_count++;
                end
                if (bus_clock_hz !== want.hz)
                begin
                    $error("bus_clock_hz: expected %0d, got %0d", want.hz, bus_clock_hz);
                    err_count++;
                end
                if (error_code !== want.err)
                begin
                    $error("error_code: expected %0d, got %0d", want.err, error_code);
                    err_count++;
                end
            end
        end
    end

    // Reset values, masking of wide writes, and read-back
    task automatic test_register_access();
        logic [ubd_pkg::APB_DATA_W-1:0] rd;
        logic [ubd_pkg::APB_DATA_W-1:0] want;
        int                             i;
        for (i = 0; i < 4; i++)
        begin
            apb_read(2'(i), rd);
            if (rd !== '0)
            begin
                $error("prdata: expected 0, got %0h", rd);
                err_count++;
            end
        end
        for (i = 0; i < 8; i++)
        begin
            apb_write(2'(i), $urandom);
            case (2'(i))
                ubd_pkg::REG_CLOCK_SOURCE: want = {30'd0, cfg_src};
                ubd_pkg::REG_AHB_PRESCALE: want = {28'd0, cfg_ahb};
                ubd_pkg::REG_APB_LOW:      want = {29'd0, cfg_apb_lo};
                default:                   want = {29'd0, cfg_apb_hi};
            endcase
            apb_read(2'(i), rd);
            if (rd !== want)
            begin
                $error("prdata: expected %0h, got %0h", want, rd);
                err_count++;
            end
        end
        apply_settings(ubd_pkg::SRC_INTERNAL, 4'd0, 3'd0, 3'd0);
    endtask

    // Field extremes at the full 16 MHz bus clock
    task automatic test_default_clock();
        send_request('0, 1'b0, 1'b0);
        send_request('0, 1'b1, 1'b1);
        send_request(24'd1, 1'b1, 1'b0);
        send_request(24'd1, 1'b0, 1'b1);
        send_request('1, 1'b0, 1'b0);
        send_request('1, 1'b1, 1'b1);
        send_request(24'd9600, 1'b0, 1'b0);
        send_request(24'd115200, 1'b1, 1'b1);
        wait_drained();
    endtask

    // Unsupported sources win over a zero baud rate
    task automatic test_unsupported_source();
        apb_write(ubd_pkg::REG_CLOCK_SOURCE, {30'd0, 2'd2});
        send_request('0, 1'b0, 1'b0);
        send_request(24'd9600, 1'b1, 1'b1);
        wait_drained();
        apb_write(ubd_pkg::REG_CLOCK_SOURCE, {30'd0, 2'd3});
        send_request(24'd115200, 1'b0, 1'b1);
        send_request('0, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Slowest and split bus clocks, first on the external and then on the internal source
    task automatic test_prescaler_extremes();
        apply_settings(ubd_pkg::SRC_EXTERNAL, 4'd15, 3'd7, 3'd0);
        send_request(24'd1, 1'b1, 1'b0);
        send_request(24'd300, 1'b0, 1'b0);
        send_request(24'd300, 1'b0, 1'b1);
        send_request('0, 1'b1, 1'b0);
        wait_drained();
        apply_settings(ubd_pkg::SRC_INTERNAL, 4'd7, 3'd3, 3'd4);
        send_request(24'd2400, 1'b0, 1'b1);
        send_request(24'd2400, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Rounded fraction that overflows into the mantissa and is dropped
    task automatic test_fraction_carry();
        logic [ubd_pkg::BAUD_W-1:0] baud;
        longint unsigned            scaled;
        apply_settings(ubd_pkg::SRC_INTERNAL, 4'd0, 3'd0, 3'd0);
        baud = 24'd1000;
        do
        begin
            baud++;
            scaled = (64'd25 * bus_clock_for(1'b0)) / (64'd4 * baud);
        end
        while (scaled % 100 < 97);
        send_request(baud, 1'b0, 1'b0);
        baud = 24'd1000;
        do
        begin
            baud++;
            scaled = (64'd25 * bus_clock_for(1'b0)) / (64'd2 * baud);
        end
        while (scaled % 100 < 94);
        send_request(baud, 1'b1, 1'b0);
        wait_drained();
    endtask

    // Hold the result side off while requests keep coming, so the pipe fills
    task automatic test_output_backpressure();
        int i;
        apply_settings(ubd_pkg::SRC_INTERNAL, 4'd9, 3'd5, 3'd6);
        steady_flow = 1'b1;
        hold_len    = 150;
        for (i = 0; i < 40; i++)
            send_random_request();
        steady_flow = 1'b0;
        wait_drained();
    endtask

    // Sender pauses until everything is back, then resumes
    task automatic test_sender_pause();
        int i;
        for (i = 0; i < 15; i++)
            send_random_request();
        wait_drained();
        for (i = 0; i < 15; i++)
            send_random_request();
        wait_drained();
    endtask

    // Random requests under a series of register settings
    task automatic test_random_settings();
        int         phase;
        int         i;
        logic [1:0] src;
        for (phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: apply_settings(ubd_pkg::SRC_INTERNAL, 4'd0, 3'd0, 3'd0);
                1: apply_settings(ubd_pkg::SRC_EXTERNAL, 4'd15, 3'd7, 3'd7);
                2: apply_settings(ubd_pkg::SRC_EXTERNAL, 4'd8, 3'd4, 3'd3);
                default:
                begin
                    src = ($urandom_range(0, 99) < 90) ? 2'($urandom_range(0, 1)) : 2'($urandom);
                    apply_settings(src, 4'($urandom), 3'($urandom), 3'($urandom));
                end
            endcase
            // Keep one phase free of idle cycles on both sides
            steady_flow = (phase == 3);
            for (i = 0; i < 60; i++)
                send_random_request();
            steady_flow = 1'b0;
            wait_drained();
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        in_valid            = 1'b0;
        baud_rate           = '0;
        oversample_by_eight = 1'b0;
        on_second_bus       = 1'b0;
        cfg_src             = '0;
        cfg_ahb             = '0;
        cfg_apb_lo          = '0;
        cfg_apb_hi          = '0;
        err_count           = 0;
        cycle_count         = 0;
        requests_sent       = 0;
        results_seen        = 0;
        error_results       = 0;
        settings_applied    = 0;
        steady_flow         = 1'b0;
        hold_len            = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_access();
        test_default_clock();
        test_unsupported_source();
        test_prescaler_extremes();
        test_fraction_carry();
        test_output_backpressure();
        test_sender_pause();
        test_random_settings();

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Checked %0d results for %0d requests over %0d register settings",
                 results_seen, requests_sent, settings_applied);
        $display("  including %0d error results, stalls and a full pipeline", error_results);
        if (err_count == 0 && pending_results.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
